/* hw/rtl/idla_pkg.sv */
`timescale 1ns / 1ps
package idla_pkg;

   localparam int FIELD_FEATURES = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_MODEL_FAMILY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERCEPT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE_V      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_0       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_1       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_2       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_3       = 3'd6;

   typedef struct packed {
      logic signed [15:0] feature_0;
      logic signed [15:0] feature_1;
      logic signed [15:0] feature_2;
      logic signed [15:0] feature_3;
      logic signed [15:0] v_first;
      logic signed [15:0] v_second;
      logic signed [15:0] target;
      logic               is_last;
   } req_type;

   typedef struct packed {
      logic [31:0] mean_loss;
      logic [16:0] sample_count;
   } rsp_type;

   typedef struct packed {
      logic               model_family;
      logic signed [15:0] intercept;
      logic signed [15:0] slope_v;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic        is_last;
      logic [31:0] sq;
   } dist_type;

   function automatic logic [63:0] exp_n(input int n);
      logic [63:0] e;
      e = 64'd1 << 32;
      for (int i = 0; i < n; i++)
         e = (e * 64'd4034748382 + (64'd1 << 31)) >> 32;
      return e;
   endfunction

endpackage

/* hw/rtl/idla_lane.sv */
`timescale 1ns / 1ps
module idla_lane (
   input  logic                clock,
   input  logic                en,
   input  logic signed [15:0]  a,
   input  logic signed [15:0]  b,
   output logic signed [31:0]  prod
);
   logic signed [31:0] prod_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= a * b;
      end
   end
   assign prod = prod_ff;
endmodule

/* hw/rtl/idla_mean.sv */
`timescale 1ns / 1ps
module idla_mean (
   input  logic               family,
   input  logic signed [35:0] lp,
   output logic signed [15:0] mean
);
   logic [7:0]  k;
   logic [35:0] shifted;
   logic [12:0] sig_tab [256];

   for (genvar g = 0; g < 256; g++) begin : g_tab
      localparam logic [63:0] E = idla_pkg::exp_n((g >= 128) ? g - 128 : 128 - g);
      localparam logic [63:0] DEN = (64'd1 << 32) + E;
      localparam logic [63:0] NUM = (g >= 128) ? (64'd1 << 44) : (E * 64'd4096);
      localparam logic [12:0] ENTRY = 13'((NUM + DEN / 2) / DEN);
      assign sig_tab[g] = ENTRY;
   end

   always_comb begin
      shifted = 36'(lp + 36'sd134217728);
      k = shifted[27:20];
      if (family) begin
         if (lp < -36'sd134217728) begin
            mean = 16'sd0;
         end else if (lp >= 36'sd134217728) begin
            mean = 16'sd4096;
         end else begin
            mean = {3'd0, sig_tab[k]};
         end
      end else begin
         if (lp < -36'sd134217728) begin
            mean = -16'sd32768;
         end else if (lp >= 36'sd134217728) begin
            mean = 16'sd32767;
         end else begin
            mean = lp[27:12];
         end
      end
   end
endmodule

/* hw/rtl/idla_accum.sv */
`timescale 1ns / 1ps
module idla_accum #(
   parameter int CNT_CAP = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  idla_pkg::dist_type  sqd,
   output logic                busy,
   output logic                done,
   output idla_pkg::rsp_type   result,
   input  logic                result_taken
);
   localparam logic [47:0] LOSS_MAX = 48'hFFFF_FFFF_FFFF;
   logic [47:0] sum_ff, sum_in;
   logic [16:0] cnt_ff, cnt_in;
   logic        div_ff, div_in;
   logic [5:0]  step_ff, step_in;
   logic [47:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic [24:0] dvs_ff, dvs_in;
   logic        done_ff, done_in;
   logic [31:0] mean_ff, mean_in;
   logic [16:0] scnt_ff, scnt_in;
   logic [48:0] add;
   logic [16:0] cnt_next;
   logic [48:0] trial;

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      div_in = div_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      done_in = done_ff;
      mean_in = mean_ff;
      scnt_in = scnt_ff;
      add = {1'b0, sum_ff} + {17'd0, sqd.sq};
      cnt_next = (32'(cnt_ff) < CNT_CAP) ? cnt_ff + 17'd1 : cnt_ff;
      trial = {rem_ff, quo_ff[47]} - {24'd0, dvs_ff};
      if (done_ff && result_taken) begin
         done_in = 1'b0;
      end
      if (sqd.valid) begin
         sum_in = add[48] ? LOSS_MAX : add[47:0];
         cnt_in = cnt_next;
         if (sqd.is_last) begin
            div_in = 1'b1;
            step_in = 6'd0;
            rem_in = 48'd0;
            quo_in = add[48] ? LOSS_MAX : add[47:0];
            dvs_in = {cnt_next, 8'd0};
            sum_in = 48'd0;
            cnt_in = 17'd0;
         end
      end else if (div_ff && !(step_ff == 6'd47 && done_ff && !result_taken)) begin
         // last step waits here while the previous result is still held
         if (!trial[48]) begin
            rem_in = trial[47:0];
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = {rem_ff[46:0], quo_ff[47]};
            quo_in = {quo_ff[46:0], 1'b0};
         end
         step_in = step_ff + 6'd1;
         if (step_ff == 6'd47) begin
            div_in = 1'b0;
            done_in = 1'b1;
            mean_in = (quo_in[47:32] != 16'd0) ? 32'hFFFF_FFFF : quo_in[31:0];
            scnt_in = dvs_ff[24:8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= 48'd0;
         cnt_ff <= 17'd0;
         div_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         div_ff <= div_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      mean_ff <= mean_in;
      scnt_ff <= scnt_in;
   end

   assign busy = div_ff;
   assign done = done_ff;
   assign result.mean_loss = mean_ff;
   assign result.sample_count = scnt_ff;
endmodule

/* hw/rtl/interval_distance_loss_accumulator.sv */
`timescale 1ns / 1ps
// channel | ports                  | beat
// req     | req_valid/ready/data   | one observation (idla_pkg::req_type)
// rsp     | rsp_valid/ready/data   | mean loss and count (idla_pkg::rsp_type)
// csr     | csr_valid/ready/index  | register write, csr_data holds value
// One observation per cycle while req_ready is high: lanes multiply at the
// accept edge, merge and mean are registered, then distance, square and
// accumulate. A last beat holds input off while in those registers; then a
// restoring divide runs, input held off, and its quotient is the result.
// A waiting result does not block input; the next divide holds at its final
// step until that result is taken.
// Synchronous active-high reset clears sums, counts, valid flags and CSRs.
module interval_distance_loss_accumulator #(
   parameter int NUM_FEATURES = 4,
   parameter int MAX_ITEMS = 65536
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  idla_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output idla_pkg::rsp_type         rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [idla_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]               csr_data
);
   localparam int NF = NUM_FEATURES < idla_pkg::FIELD_FEATURES ?
                       NUM_FEATURES : idla_pkg::FIELD_FEATURES;
   localparam int CNT_CAP = MAX_ITEMS < 131071 ? MAX_ITEMS : 131071;

   idla_pkg::cfg_type  cfg_ff;
   logic signed [15:0] coef_ff [idla_pkg::FIELD_FEATURES];
   logic signed [15:0] feat [idla_pkg::FIELD_FEATURES];
   logic signed [31:0] fprod [idla_pkg::FIELD_FEATURES];
   logic signed [31:0] vp0, vp1;
   logic               s1_ff, s2_ff;
   logic               l1_ff, l2_ff;
   logic signed [15:0] t1_ff, t2_ff;
   logic signed [15:0] m0_ff, m1_ff;
   logic signed [35:0] xb, lp0, lp1;
   logic signed [15:0] m0, m1, lo, hi;
   logic signed [16:0] d;
   logic [31:0]        sq;
   idla_pkg::dist_type sqd;
   logic               busy, done, accept;

   assign feat[0] = req_data.feature_0;
   assign feat[1] = req_data.feature_1;
   assign feat[2] = req_data.feature_2;
   assign feat[3] = req_data.feature_3;

   assign req_ready = !busy && !((s1_ff && l1_ff) || (s2_ff && l2_ff));
   assign accept = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         for (int i = 0; i < idla_pkg::FIELD_FEATURES; i++) begin
            coef_ff[i] <= 16'sd0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            idla_pkg::CSR_MODEL_FAMILY: cfg_ff.model_family <= csr_data[0];
            idla_pkg::CSR_INTERCEPT: cfg_ff.intercept <= csr_data;
            idla_pkg::CSR_SLOPE_V: cfg_ff.slope_v <= csr_data;
            default: begin
               if (csr_index >= idla_pkg::CSR_COEF_0 && csr_index <= idla_pkg::CSR_COEF_3) begin
                  coef_ff[2'(csr_index - idla_pkg::CSR_COEF_0)] <= csr_data;
               end
            end
         endcase
      end
   end

   for (genvar g = 0; g < idla_pkg::FIELD_FEATURES; g++) begin : g_lane
      idla_lane u_lane (.clock(clock), .en(accept), .a(feat[g]), .b(coef_ff[g]),
                        .prod(fprod[g]));
   end
   idla_lane u_v0 (.clock(clock), .en(accept), .a(req_data.v_first),
                   .b(cfg_ff.slope_v), .prod(vp0));
   idla_lane u_v1 (.clock(clock), .en(accept), .a(req_data.v_second),
                   .b(cfg_ff.slope_v), .prod(vp1));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else begin
         s1_ff <= accept;
         s2_ff <= s1_ff;
      end
      if (accept) begin
         l1_ff <= req_data.is_last;
         t1_ff <= req_data.target;
      end
      l2_ff <= l1_ff;
      t2_ff <= t1_ff;
      m0_ff <= m0;
      m1_ff <= m1;
   end

   always_comb begin
      xb = 36'sd0;
      for (int i = 0; i < NF; i++) begin
         xb = xb + 36'(fprod[i]);
      end
      lp0 = xb + 36'(vp0) + 36'(cfg_ff.intercept) * 36'sd4096;
      lp1 = xb + 36'(vp1) + 36'(cfg_ff.intercept) * 36'sd4096;
   end

   idla_mean u_m0 (.family(cfg_ff.model_family), .lp(lp0), .mean(m0));
   idla_mean u_m1 (.family(cfg_ff.model_family), .lp(lp1), .mean(m1));

   always_comb begin
      lo = (m0_ff < m1_ff) ? m0_ff : m1_ff;
      hi = (m0_ff < m1_ff) ? m1_ff : m0_ff;
      if (t2_ff < lo) begin
         d = 17'(lo) - 17'(t2_ff);
      end else if (t2_ff > hi) begin
         d = 17'(t2_ff) - 17'(hi);
      end else begin
         d = 17'sd0;
      end
      sq = 32'(d * d);
      sqd.valid = s2_ff;
      sqd.is_last = l2_ff;
      sqd.sq = sq;
   end

   idla_accum #(.CNT_CAP(CNT_CAP)) u_acc (
      .clock(clock), .reset(reset), .sqd(sqd), .busy(busy), .done(done),
      .result(rsp_data), .result_taken(rsp_ready)
   );
   assign rsp_valid = done;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !accept) else $error("beat taken during divide");
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
   a_last_divides: assert property (@(posedge clock) disable iff (reset)
      (sqd.valid && sqd.is_last) |=> busy) else $error("divide not started");
endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   idla_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   idla_pkg::rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [idla_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   interval_distance_loss_accumulator uut (.*);

   always #5 clock = ~clock;

   localparam longint LOSS_CAP = (64'd1 << 48) - 1;
   localparam int COUNT_LIMIT = 65536;

   logic [15:0] logistic_lut [256];
   logic fam_logistic;
   longint icpt, slope, coef [4];
   longint loss_acc;
   int obs_count;
   idla_pkg::rsp_type loss_expected [$];
   int failures = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   function automatic void build_lut();
      longint unsigned e [129];
      longint unsigned num, den;
      e[0] = 64'd1 << 32;
      for (int n = 1; n <= 128; n++)
         e[n] = (e[n-1] * 64'd4034748382 + (64'd1 << 31)) >> 32;
      for (int k = 0; k < 256; k++) begin
         if (k >= 128) begin
            den = (64'd1 << 32) + e[k-128];
            num = 64'd1 << 44;
         end else begin
            den = (64'd1 << 32) + e[128-k];
            num = e[128-k] * 4096;
         end
         logistic_lut[k] = 16'((num + den / 2) / den);
      end
   endfunction

   function automatic longint link_mean(longint lp);
      longint one = 64'sd1 << 24;
      if (fam_logistic) begin
         if (lp < -8 * one) return 0;
         if (lp >= 8 * one) return 4096;
         return logistic_lut[((lp + 8 * one) >>> 20) & 255];
      end
      if (lp < -64'sd32768 * 4096) return -32768;
      if (lp >= 64'sd32768 * 4096) return 32767;
      return ((lp + 64'sd32768 * 4096) >>> 12) - 32768;
   endfunction

   function automatic void predict_loss(idla_pkg::req_type r);
      longint xb, lp0, lp1, f0, f1, lo, hi, t, sq;
      idla_pkg::rsp_type o;
      xb = longint'(r.feature_0) * coef[0] + longint'(r.feature_1) * coef[1]
         + longint'(r.feature_2) * coef[2] + longint'(r.feature_3) * coef[3];
      lp0 = icpt * 4096 + slope * longint'(r.v_first) + xb;
      lp1 = icpt * 4096 + slope * longint'(r.v_second) + xb;
      f0 = link_mean(lp0);
      f1 = link_mean(lp1);
      lo = f0 < f1 ? f0 : f1;
      hi = f0 < f1 ? f1 : f0;
      t = longint'(r.target);
      sq = 0;
      if (t < lo) sq = (lo - t) * (lo - t);
      else if (t > hi) sq = (t - hi) * (t - hi);
      loss_acc = (sq > LOSS_CAP - loss_acc) ? LOSS_CAP : loss_acc + sq;
      if (obs_count < COUNT_LIMIT) obs_count++;
      if (r.is_last) begin
         longint unsigned q;
         q = longint'(loss_acc) / (longint'(obs_count) * 256);
         o.mean_loss = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
         o.sample_count = 17'(obs_count);
         loss_expected.push_back(o);
         loss_acc = 0;
         obs_count = 0;
      end
   endfunction

   task automatic write_reg(logic [idla_pkg::CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         idla_pkg::CSR_MODEL_FAMILY: fam_logistic = val[0];
         idla_pkg::CSR_INTERCEPT: icpt = longint'($signed(val));
         idla_pkg::CSR_SLOPE_V: slope = longint'($signed(val));
         default: coef[idx - idla_pkg::CSR_COEF_0] = longint'($signed(val));
      endcase
      @(negedge clock);
   endtask

   task automatic send_obs(idla_pkg::req_type r);
      csr_valid <= 0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predict_loss(r);
      @(negedge clock);
   endtask

   task automatic drain();
      int guard = 0;
      req_valid <= 0;
      csr_valid <= 0;
      while (loss_expected.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (60) @(negedge clock);
   endtask

   task automatic set_model(bit fam, logic [15:0] ic, logic [15:0] sl,
                            logic [15:0] c0, logic [15:0] c1,
                            logic [15:0] c2, logic [15:0] c3);
      drain();
      write_reg(idla_pkg::CSR_MODEL_FAMILY, {15'd0, fam});
      write_reg(idla_pkg::CSR_INTERCEPT, ic);
      write_reg(idla_pkg::CSR_SLOPE_V, sl);
      write_reg(idla_pkg::CSR_COEF_0, c0);
      write_reg(idla_pkg::CSR_COEF_1, c1);
      write_reg(idla_pkg::CSR_COEF_2, c2);
      write_reg(idla_pkg::CSR_COEF_3, c3);
   endtask

   function automatic logic [15:0] rand_q();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(8192)) - 16'd4096;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic idla_pkg::req_type rand_obs(bit last);
      idla_pkg::req_type r;
      r.feature_0 = rand_q();
      r.feature_1 = rand_q();
      r.feature_2 = rand_q();
      r.feature_3 = rand_q();
      r.v_first = rand_q();
      r.v_second = rand_q();
      r.target = rand_q();
      r.is_last = last;
      return r;
   endfunction

   task automatic test_directed();
      idla_pkg::req_type r;
      set_model(0, 16'h1000, 16'h1000, 16'h0800, 16'hF800, 16'h0400, 16'h0000);
      r = '0;
      r.is_last = 1;
      send_obs(r);
      r = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b0};
      send_obs(r);
      r = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1};
      send_obs(r);
      set_model(0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      for (int i = 0; i < 4; i++) begin
         r = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
               16'h8000, i == 3};
         send_obs(r);
      end
      set_model(1, 16'h0000, 16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      for (int k = -9; k <= 9; k += 3) begin
         r = '0;
         r.v_first = 16'(k * 4096);
         r.v_second = 16'(k * 4096 + 256);
         r.target = (k < 0) ? 16'h1000 : 16'hF000;
         r.is_last = (k == 9);
         send_obs(r);
      end
      r = '0;
      r.v_first = 16'h1000;
      r.v_second = 16'hF000;
      r.target = 16'h0400;
      r.is_last = 1;
      send_obs(r);
   endtask

   task automatic test_random(int n_items);
      int left = n_items;
      while (left > 0) begin
         int len = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
         for (int i = 0; i < len && left > 0; i++) begin
            send_obs(rand_obs(i == len - 1 || left == 1));
            left--;
         end
      end
   endtask

   task automatic test_idling();
      send_idle_pct = 0; recv_stall_pct = 0;
      test_random(90);
      set_model(1, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
      send_idle_pct = 79; recv_stall_pct = 0;
      test_random(90);
      drain();
      send_idle_pct = 0; recv_stall_pct = 79;
      test_random(90);
      set_model(0, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
      send_idle_pct = 21; recv_stall_pct = 21;
      test_random(90);
      set_model(1, 16'($urandom_range(4096)), 16'($urandom_range(2048)),
                16'($urandom_range(512)), 16'($urandom_range(512)),
                16'($urandom_range(512)), 16'($urandom_range(512)));
      send_idle_pct = 0; recv_stall_pct = 0;
      test_random(90);
   endtask

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (loss_expected.size() == 0) begin
            $error("unexpected beat: mean_loss %0d sample_count %0d",
                   rsp_data.mean_loss, rsp_data.sample_count);
            failures++;
         end else begin
            idla_pkg::rsp_type e;
            e = loss_expected.pop_front();
            if (rsp_data.mean_loss !== e.mean_loss) begin
               $error("mean_loss expected %0d actual %0d", e.mean_loss, rsp_data.mean_loss);
               failures++;
            end
            if (rsp_data.sample_count !== e.sample_count) begin
               $error("sample_count expected %0d actual %0d",
                      e.sample_count, rsp_data.sample_count);
               failures++;
            end
         end
      end
   end

   initial begin
      build_lut();
      fam_logistic = 0; icpt = 0; slope = 0;
      coef = '{0, 0, 0, 0};
      loss_acc = 0; obs_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_idling();
      drain();
      if (failures == 0 && loss_expected.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end
endmodule

/* files.f */
hw/rtl/idla_pkg.sv
hw/rtl/idla_lane.sv
hw/rtl/idla_mean.sv
hw/rtl/idla_accum.sv
hw/rtl/interval_distance_loss_accumulator.sv
verif/tb_top.sv
